>>> hw/rtl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types, constants and helpers of the five-to-three class merge.
// ----------------------------------------------------------------------------
package cpm_pkg;

    localparam int WFRAC     = 16;              // fraction bits of a weight
    localparam int WGT_W     = WFRAC + 1;       // weight register width
    localparam int PROB_W    = 8;
    localparam int SUM_W     = 11;              // sum of five probabilities
    localparam int PROD_W    = WGT_W + PROB_W;  // weight times probability
    localparam int T_W       = SUM_W + WFRAC;   // merged class sum
    localparam int WIDE_W    = T_W + 9;         // 510 * t + S * 2^WFRAC
    localparam int NUM_W     = WIDE_W - WFRAC - 1;
    localparam int DIV_STG   = PROB_W;          // one quotient bit per stage
    localparam int CFG_IDX_W = 2;

    localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << WFRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_LOW  = 2'd0,
        CFG_WEIGHT_HIGH = 2'd1,
        CFG_BG_LABEL    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic upd;      // old label reached the threshold
        logic zero;     // all five probabilities are zero
    } side_t;

    // weights above 1.0 saturate to 1.0
    function automatic logic [WGT_W-1:0] clamp_weight(input logic [WGT_W-1:0] v);
        return (v > W_ONE) ? W_ONE : v;
    endfunction

endpackage

>>> hw/rtl/cpm_div.sv
// ----------------------------------------------------------------------------
// cpm_div
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module cpm_div
    import cpm_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_STG-1:0]   en,     // load enable of each stage
    input  logic [NUM_W-1:0]     num,
    input  logic [SUM_W-1:0]     den,
    output logic [PROB_W-1:0]    quot
);

    logic [NUM_W-1:0]  rem_reg [DIV_STG-1];
    logic [SUM_W-1:0]  den_reg [DIV_STG-1];
    logic [PROB_W-1:0] q_reg   [DIV_STG];

    logic [NUM_W-1:0]  rem_in  [DIV_STG];
    logic [SUM_W-1:0]  den_in  [DIV_STG];
    logic [PROB_W-1:0] q_in    [DIV_STG];
    logic [NUM_W-1:0]  rem_next[DIV_STG];
    logic [PROB_W-1:0] q_next  [DIV_STG];

    always_comb
    begin
        for (int j = 0; j < DIV_STG; j++)
        begin
            if (j == 0)
            begin
                rem_in[j] = num;
                den_in[j] = den;
                q_in[j]   = '0;
            end
            else
            begin
                rem_in[j] = rem_reg[j-1];
                den_in[j] = den_reg[j-1];
                q_in[j]   = q_reg[j-1];
            end
        end
    end

    always_comb
    begin
        logic [NUM_W-1:0] trial;
        for (int j = 0; j < DIV_STG; j++)
        begin
            trial = NUM_W'(den_in[j]) << (DIV_STG - 1 - j);
            if (rem_in[j] >= trial)
            begin
                rem_next[j] = rem_in[j] - trial;
                q_next[j]   = q_in[j] | (PROB_W'(1) << (DIV_STG - 1 - j));
            end
            else
            begin
                rem_next[j] = rem_in[j];
                q_next[j]   = q_in[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STG; j++)
        begin
            if (en[j])
            begin
                q_reg[j] <= q_next[j];
                if (j < DIV_STG - 1)
                begin
                    rem_reg[j] <= rem_next[j];
                    den_reg[j] <= den_in[j];
                end
            end
        end
    end

    assign quot = q_reg[DIV_STG-1];

endmodule

>>> hw/rtl/five_to_three_class_prob_merge.sv
// ----------------------------------------------------------------------------
// five_to_three_class_prob_merge
// Merges five class probabilities of a voxel into three and relabels it.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis (one voxel per item); results leave on
// m_axis, one result per input item, in order. cfg writes weight_low,
// weight_high and bg_label by index; cfg_ready is always high and a
// write to an unknown index is dropped. Weights are Q1.16, above 1.0
// they saturate. Write configuration only while the pipe is empty.
// An item passes a multiply stage, two add stages, an 8-stage
// bit-per-stage divider (three in parallel, one per merged class) and
// the output register with argmax. Throughput is one item per cycle
// while m_axis is ready. Every stage holds its own valid bit, so when
// m_axis stalls the pipe keeps filling until all 12 stages hold items,
// then s_axis_tready drops; nothing is lost or repeated.
// Reset empties the pipe and loads weights of 0.5 and bg_label 1.
// ----------------------------------------------------------------------------
module five_to_three_class_prob_merge
    import cpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // prob_class0, prob_class1, prob_class2, prob_class3, prob_class4, label_in
    input  logic [47:0]           s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_prob0, new_prob1, new_prob2, label_out
    output logic [31:0]           m_axis_tdata,
    // updated
    output logic [0:0]            m_axis_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WGT_W-1:0]      cfg_data
);

    localparam int NSTG  = DIV_STG + 4;
    localparam int ST_D0 = 3;
    localparam int ST_E  = NSTG - 1;

    // configuration
    logic [WGT_W-1:0]  weight_low_reg;
    logic [WGT_W-1:0]  weight_high_reg;
    logic [PROB_W-1:0] bg_label_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_low_reg  <= W_ONE >> 1;
            weight_high_reg <= W_ONE >> 1;
            bg_label_reg    <= PROB_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WEIGHT_LOW:  weight_low_reg  <= clamp_weight(cfg_data);
                CFG_WEIGHT_HIGH: weight_high_reg <= clamp_weight(cfg_data);
                CFG_BG_LABEL:    bg_label_reg    <= cfg_data[PROB_W-1:0];
                default:         ;
            endcase
        end
    end

    // per-stage valid and ready
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] vin;

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign vin           = {v_reg[NSTG-2:0], s_axis_tvalid};
    assign s_axis_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NSTG; i++)
                if (rdy[i])
                    v_reg[i] <= vin[i];
        end
    end

    // side flags travel with the item up to the output stage
    side_t side_reg [ST_E];
    side_t side_a;

    logic [PROB_W-1:0] in_p0, in_p1, in_p2, in_p3, in_p4, in_lbl;

    assign in_p0  = s_axis_tdata[7:0];
    assign in_p1  = s_axis_tdata[15:8];
    assign in_p2  = s_axis_tdata[23:16];
    assign in_p3  = s_axis_tdata[31:24];
    assign in_p4  = s_axis_tdata[39:32];
    assign in_lbl = s_axis_tdata[47:40];

    logic [SUM_W-1:0] in_sum;
    assign in_sum = SUM_W'(in_p0) + SUM_W'(in_p1) + SUM_W'(in_p2)
                  + SUM_W'(in_p3) + SUM_W'(in_p4);

    assign side_a.upd  = (in_lbl >= bg_label_reg);
    assign side_a.zero = (in_sum == '0);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ST_E; i++)
            if (rdy[i])
                side_reg[i] <= (i == 0) ? side_a : side_reg[(i == 0) ? 0 : i - 1];
    end

    // stage A: weight products
    logic [PROB_W-1:0] a_p0_reg, a_p2_reg, a_p4_reg;
    logic [PROD_W-1:0] a_lo1_reg, a_hi1_reg, a_lo3_reg, a_hi3_reg;
    logic [SUM_W-1:0]  a_sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_p0_reg  <= in_p0;
            a_p2_reg  <= in_p2;
            a_p4_reg  <= in_p4;
            a_lo1_reg <= PROD_W'(weight_low_reg) * PROD_W'(in_p1);
            a_hi1_reg <= PROD_W'(W_ONE - weight_low_reg) * PROD_W'(in_p1);
            a_lo3_reg <= PROD_W'(weight_high_reg) * PROD_W'(in_p3);
            a_hi3_reg <= PROD_W'(W_ONE - weight_high_reg) * PROD_W'(in_p3);
            a_sum_reg <= in_sum;
        end
    end

    // stage B: merged sums scaled by 2^WFRAC
    logic [T_W-1:0]   b_t0_reg, b_t1_reg, b_t2_reg;
    logic [SUM_W-1:0] b_sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b_t0_reg  <= (T_W'(a_p0_reg) << WFRAC) + T_W'(a_lo1_reg);
            b_t1_reg  <= (T_W'(a_p2_reg) << WFRAC) + T_W'(a_hi1_reg) + T_W'(a_lo3_reg);
            b_t2_reg  <= (T_W'(a_p4_reg) << WFRAC) + T_W'(a_hi3_reg);
            b_sum_reg <= a_sum_reg;
        end
    end

    // stage C: dividend (510*t + S*2^WFRAC) / 2^(WFRAC+1); divisor is the plain sum
    function automatic logic [NUM_W-1:0] dividend(input logic [T_W-1:0]   t,
                                                  input logic [SUM_W-1:0] s);
        logic [WIDE_W-1:0] w;
        w = (WIDE_W'(t) << 9) - (WIDE_W'(t) << 1) + (WIDE_W'(s) << WFRAC);
        return w[WIDE_W-1 -: NUM_W];
    endfunction

    logic [NUM_W-1:0] c_num0_reg, c_num1_reg, c_num2_reg;
    logic [SUM_W-1:0] c_sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            c_num0_reg <= dividend(b_t0_reg, b_sum_reg);
            c_num1_reg <= dividend(b_t1_reg, b_sum_reg);
            c_num2_reg <= dividend(b_t2_reg, b_sum_reg);
            c_sum_reg  <= b_sum_reg;
        end
    end

    // stages D: three dividers in parallel
    logic [DIV_STG-1:0] div_en;
    logic [PROB_W-1:0]  q0, q1, q2;

    assign div_en = rdy[ST_D0 +: DIV_STG];

    cpm_div u_div0 (.clk(clk), .en(div_en), .num(c_num0_reg), .den(c_sum_reg), .quot(q0));
    cpm_div u_div1 (.clk(clk), .en(div_en), .num(c_num1_reg), .den(c_sum_reg), .quot(q1));
    cpm_div u_div2 (.clk(clk), .en(div_en), .num(c_num2_reg), .den(c_sum_reg), .quot(q2));

    // stage E: argmax, label and output register
    side_t             e_side;
    logic [PROB_W-1:0] n0, n1, n2, best;
    logic [1:0]        idx;
    logic [PROB_W-1:0] lbl_next;

    logic              upd_reg;
    logic [PROB_W-1:0] np0_reg, np1_reg, np2_reg, lbl_reg;

    assign e_side = side_reg[ST_E-1];

    always_comb
    begin
        n0 = e_side.zero ? '0 : q0;
        n1 = e_side.zero ? '0 : q1;
        n2 = e_side.zero ? '0 : q2;
        idx  = 2'd0;
        best = n0;
        if (n1 > best)
        begin
            idx  = 2'd1;
            best = n1;
        end
        if (n2 > best)
            idx = 2'd2;
        lbl_next = bg_label_reg + PROB_W'(idx);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_E])
        begin
            upd_reg <= e_side.upd;
            np0_reg <= e_side.upd ? n0 : '0;
            np1_reg <= e_side.upd ? n1 : '0;
            np2_reg <= e_side.upd ? n2 : '0;
            lbl_reg <= e_side.upd ? lbl_next : '0;
        end
    end

    assign m_axis_tvalid = v_reg[ST_E];
    assign m_axis_tdata  = {lbl_reg, np2_reg, np1_reg, np0_reg};
    assign m_axis_tuser  = upd_reg;

endmodule
